>>> rtl/gbnms_pkg.sv
// types and constants shared by the greedy box nms blocks
// no dependencies
`default_nettype none

package gbnms_pkg;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned AreaW  = 24;
  localparam int unsigned UnionW = 25;
  localparam int unsigned ProdW  = 41;

  localparam logic [15:0] SuppressIouRst   = 16'd19661;
  localparam logic [15:0] MergeIouRst      = 16'd58982;
  localparam logic [15:0] MergeScoreGapRst = 16'd9830;

  typedef enum logic [1:0] {
    CFG_SUPPRESS_IOU    = 2'd0,
    CFG_MERGE_IOU       = 2'd1,
    CFG_MERGE_SCORE_GAP = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        frame_start;
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] score;
    logic [3:0]  cls;
    logic [1:0]  color;
  } box_t;

  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] top;
    logic [11:0] width;
    logic [11:0] height;
    logic [AreaW-1:0] area;
    logic [15:0] score;
    logic [3:0]  cls;
    logic [1:0]  color;
  } entry_t;

  typedef struct packed {
    logic [15:0] suppress_iou;
    logic [15:0] merge_iou;
    logic [15:0] merge_score_gap;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    logic             sup;
    logic             mrg;
    logic [SlotW-1:0] idx;
  } hit_t;

endpackage

`default_nettype wire

>>> rtl/gbnms_if.sv
// request channel interfaces: box input, result output, register writes
// no dependencies
`default_nettype none

interface gbnms_box_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [12:0] box_left;
  logic signed [12:0] box_top;
  logic [11:0]        box_width;
  logic [11:0]        box_height;
  logic [15:0]        box_score;
  logic [3:0]         box_cls;
  logic [1:0]         box_hue;

  modport source (output valid, frame_start, box_left, box_top, box_width, box_height,
                  box_score, box_cls, box_hue, input ready);
  modport sink (input valid, frame_start, box_left, box_top, box_width, box_height,
                box_score, box_cls, box_hue, output ready);
endinterface

interface gbnms_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  box_number;
  logic        kept;
  logic [5:0]  kept_slot;
  logic [63:0] merge_mask;

  modport source (output valid, box_number, kept, kept_slot, merge_mask, input ready);
  modport sink (input valid, box_number, kept, kept_slot, merge_mask, output ready);
endinterface

interface gbnms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/greedy_box_nms_with_merge.sv
// Greedy box NMS with merge reporting. Each accepted box is checked against
// every box kept so far in the frame; the table is read one kept slot per
// cycle through its single read port into a six-stage pipelined IoU compare
// unit, so in_ready stays low until every compare has left the unit and the
// output register is free for the result (the previous result taken).
// One result per box. A result waiting in the output register does not block
// the next request. Register writes are taken every cycle; write them only
// while idle.
// depends on gbnms_pkg, gbnms_if, gbnms_table, gbnms_iou
`default_nettype none

module greedy_box_nms_with_merge #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  gbnms_box_if.sink    box_i,
  gbnms_res_if.source  res_o,
  gbnms_cfg_if.sink    cfg_i
);
  import gbnms_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  state_e state_q, state_d;
  cfg_t   cfg_q;
  box_t   box_q;
  logic [AreaW-1:0] area_q;
  logic [CntW-1:0]  count_q, issue_q;
  logic [SlotW-1:0] counter_q, number_q;
  logic             keep_q;
  logic [63:0]      mask_q;

  logic out_vld_q;
  logic [SlotW-1:0] out_number_q, out_slot_q;
  logic out_kept_q;
  logic [63:0] out_mask_q;

  logic in_acc, rd_en, scan_done, fin_go, stored;
  logic tbl_vld;
  logic [IdxW-1:0] tbl_idx;
  entry_t tbl_data, wr_data;
  hit_t hit;
  logic unit_busy;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.suppress_iou    <= SuppressIouRst;
      cfg_q.merge_iou       <= MergeIouRst;
      cfg_q.merge_score_gap <= MergeScoreGapRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_SUPPRESS_IOU:    cfg_q.suppress_iou    <= cfg_i.data;
        CFG_MERGE_IOU:       cfg_q.merge_iou       <= cfg_i.data;
        CFG_MERGE_SCORE_GAP: cfg_q.merge_score_gap <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sequencer
  assign in_acc    = box_i.valid && box_i.ready;
  assign scan_done = (issue_q == count_q) && !tbl_vld && !unit_busy;
  assign fin_go    = !out_vld_q || res_o.ready;
  assign stored    = keep_q && (count_q < CntW'(MAX_BOXES));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    box_i.ready = 1'b0;
    rd_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: box_i.ready = 1'b1;
      ST_SCAN: rd_en = (issue_q < count_q);
      ST_FIN:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      counter_q <= '0;
      issue_q   <= '0;
      keep_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        issue_q <= '0;
        keep_q  <= 1'b1;
        if (box_i.frame_start) begin
          count_q   <= '0;
          counter_q <= SlotW'(1);
        end else begin
          counter_q <= counter_q + SlotW'(1);
        end
      end
      if (rd_en) begin
        issue_q <= issue_q + CntW'(1);
      end
      if (hit.vld && hit.sup) begin
        keep_q <= 1'b0;
      end
      if (state_q == ST_FIN && fin_go) begin
        out_vld_q <= 1'b1;
        if (stored) begin
          count_q <= count_q + CntW'(1);
        end
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      box_q.frame_start <= box_i.frame_start;
      box_q.left        <= box_i.box_left;
      box_q.top         <= box_i.box_top;
      box_q.width       <= box_i.box_width;
      box_q.height      <= box_i.box_height;
      box_q.score       <= box_i.box_score;
      box_q.cls         <= box_i.box_cls;
      box_q.color       <= box_i.box_hue;
      area_q            <= AreaW'(box_i.box_width) * AreaW'(box_i.box_height);
      number_q          <= box_i.frame_start ? '0 : counter_q;
      mask_q            <= '0;
    end else if (hit.vld && hit.mrg) begin
      mask_q[hit.idx] <= 1'b1;
    end
    if (state_q == ST_FIN && fin_go) begin
      out_number_q <= number_q;
      out_kept_q   <= stored;
      out_slot_q   <= stored ? SlotW'(count_q) : '0;
      out_mask_q   <= mask_q;
    end
  end

  always_comb begin
    wr_data.left   = box_q.left;
    wr_data.top    = box_q.top;
    wr_data.width  = box_q.width;
    wr_data.height = box_q.height;
    wr_data.area   = area_q;
    wr_data.score  = box_q.score;
    wr_data.cls    = box_q.cls;
    wr_data.color  = box_q.color;
  end

  gbnms_table #(
    .Depth (MAX_BOXES),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (state_q == ST_FIN && fin_go && stored),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[IdxW-1:0]),
    .rd_vld_o  (tbl_vld),
    .rd_idx_o  (tbl_idx),
    .rd_data_o (tbl_data)
  );

  gbnms_iou u_iou (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (tbl_vld),
    .in_idx_i   (SlotW'(tbl_idx)),
    .entry_i    (tbl_data),
    .box_i      (box_q),
    .box_area_i (area_q),
    .cfg_i      (cfg_q),
    .hit_o      (hit),
    .busy_o     (unit_busy)
  );

  assign res_o.valid      = out_vld_q;
  assign res_o.box_number = out_number_q;
  assign res_o.kept       = out_kept_q;
  assign res_o.kept_slot  = out_slot_q;
  assign res_o.merge_mask = out_mask_q;

endmodule

`default_nettype wire

>>> rtl/gbnms_table.sv
// kept box table: one write port, one registered read port
// depends on gbnms_pkg
`default_nettype none

module gbnms_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [IdxW-1:0]     wr_addr_i,
  input  wire gbnms_pkg::entry_t   wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [IdxW-1:0]     rd_addr_i,
  output logic                     rd_vld_o,
  output logic [IdxW-1:0]          rd_idx_o,
  output gbnms_pkg::entry_t        rd_data_o
);
  import gbnms_pkg::*;

  entry_t mem_q [Depth];
  logic   rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_idx_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_i;
    end
  end

  assign rd_vld_o  = rd_vld_q;
  assign rd_idx_o  = rd_idx_q;
  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/gbnms_iou.sv
// pipelined overlap / iou compare unit, one kept entry per cycle
// depends on gbnms_pkg
`default_nettype none

module gbnms_iou (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_vld_i,
  input  wire logic [gbnms_pkg::SlotW-1:0]  in_idx_i,
  input  wire gbnms_pkg::entry_t            entry_i,
  input  wire gbnms_pkg::box_t              box_i,
  input  wire logic [gbnms_pkg::AreaW-1:0]  box_area_i,
  input  wire gbnms_pkg::cfg_t              cfg_i,
  output gbnms_pkg::hit_t                   hit_o,
  output logic                              busy_o
);
  import gbnms_pkg::*;

  // stage 1: overlap corners, tag compare
  logic signed [13:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
  logic signed [13:0] x1_d, x2_d, y1_d, y2_d;
  logic [15:0] gap_d;
  logic        tag_ok_d;
  logic        v1_q;
  logic signed [13:0] x1_q, x2_q, y1_q, y2_q;
  logic [AreaW-1:0] ka1_q;
  logic        tok1_q;
  logic [SlotW-1:0] idx1_q;

  always_comb begin
    a_l = {box_i.left[12], box_i.left};
    a_t = {box_i.top[12], box_i.top};
    a_r = a_l + $signed({2'b00, box_i.width});
    a_b = a_t + $signed({2'b00, box_i.height});
    b_l = {entry_i.left[12], entry_i.left};
    b_t = {entry_i.top[12], entry_i.top};
    b_r = b_l + $signed({2'b00, entry_i.width});
    b_b = b_t + $signed({2'b00, entry_i.height});
    x1_d = (a_l > b_l) ? a_l : b_l;
    y1_d = (a_t > b_t) ? a_t : b_t;
    x2_d = (a_r < b_r) ? a_r : b_r;
    y2_d = (a_b < b_b) ? a_b : b_b;
    gap_d = (box_i.score > entry_i.score) ? (box_i.score - entry_i.score)
                                          : (entry_i.score - box_i.score);
    tag_ok_d = (gap_d < cfg_i.merge_score_gap) && (box_i.cls == entry_i.cls) &&
               (box_i.color == entry_i.color);
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    y1_q   <= y1_d;
    y2_q   <= y2_d;
    ka1_q  <= entry_i.area;
    tok1_q <= tag_ok_d;
    idx1_q <= in_idx_i;
  end

  // stage 2: clipped extents
  logic signed [13:0] dxw, dyw;
  logic [11:0] dx_d, dy_d;
  logic        v2_q;
  logic [11:0] dx_q, dy_q;
  logic [AreaW-1:0] ka2_q;
  logic        tok2_q;
  logic [SlotW-1:0] idx2_q;

  always_comb begin
    dxw  = x2_q - x1_q;
    dyw  = y2_q - y1_q;
    dx_d = (x2_q > x1_q) ? dxw[11:0] : 12'd0;
    dy_d = (y2_q > y1_q) ? dyw[11:0] : 12'd0;
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ka2_q  <= ka1_q;
    tok2_q <= tok1_q;
    idx2_q <= idx1_q;
  end

  // stage 3: intersection area
  logic        v3_q;
  logic [AreaW-1:0] inter3_q, ka3_q;
  logic        tok3_q;
  logic [SlotW-1:0] idx3_q;

  always_ff @(posedge clk_i) begin
    inter3_q <= AreaW'(dx_q) * AreaW'(dy_q);
    ka3_q    <= ka2_q;
    tok3_q   <= tok2_q;
    idx3_q   <= idx2_q;
  end

  // stage 4: union
  logic        v4_q;
  logic [UnionW-1:0] uni4_q;
  logic [AreaW-1:0]  inter4_q;
  logic        tok4_q;
  logic [SlotW-1:0] idx4_q;

  always_ff @(posedge clk_i) begin
    uni4_q   <= {1'b0, box_area_i} + {1'b0, ka3_q} - {1'b0, inter3_q};
    inter4_q <= inter3_q;
    tok4_q   <= tok3_q;
    idx4_q   <= idx3_q;
  end

  // stage 5: threshold products
  logic        v5_q;
  logic [ProdW-1:0] ps5_q, pm5_q, sc5_q;
  logic        nan5_q;
  logic        tok5_q;
  logic [SlotW-1:0] idx5_q;

  always_ff @(posedge clk_i) begin
    ps5_q  <= ProdW'(cfg_i.suppress_iou) * ProdW'(uni4_q);
    pm5_q  <= ProdW'(cfg_i.merge_iou) * ProdW'(uni4_q);
    sc5_q  <= {1'b0, inter4_q, 16'd0};
    nan5_q <= (uni4_q == '0);
    tok5_q <= tok4_q;
    idx5_q <= idx4_q;
  end

  // stage 6: decision
  hit_t hit_d, hit_q;

  always_comb begin
    hit_d.vld = v5_q;
    hit_d.sup = nan5_q || (sc5_q > ps5_q);
    hit_d.mrg = !nan5_q && (sc5_q > ps5_q) && (sc5_q > pm5_q) && tok5_q;
    hit_d.idx = idx5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      hit_q <= '0;
    end else begin
      v1_q  <= in_vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      hit_q <= hit_d;
    end
  end

  assign hit_o  = hit_q;
  assign busy_o = v1_q | v2_q | v3_q | v4_q | v5_q | hit_q.vld;

endmodule

`default_nettype wire

>>> rtl/gbnms_checker.sv
// port level checks for the greedy box nms block, bound to the top level
// depends on greedy_box_nms_with_merge
`default_nettype none

module gbnms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_kept_i,
  input wire logic [5:0]  out_slot_i,
  input wire logic [63:0] out_mask_i
);

  // a kept box is never absorbed by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!out_kept_i || out_mask_i == 64'd0))
    else $error("kept box reports merge bits");

  // dropped box reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_kept_i |-> out_slot_i == 6'd0)
    else $error("dropped box has nonzero slot");

  // one box in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while a box is in work");

  // pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mask_i) && $stable(out_kept_i))
    else $error("result changed before taken");

endmodule

bind greedy_box_nms_with_merge gbnms_checker u_gbnms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (box_i.valid),
  .in_ready_i  (box_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kept_i  (res_o.kept),
  .out_slot_i  (res_o.kept_slot),
  .out_mask_i  (res_o.merge_mask)
);

`default_nettype wire
